FILE: rtl/core/frs_pkg.sv
// Shared constants, register indexes and control structs of the frame rate smoother.
package frs_pkg;

  localparam int STAMP_W    = 32;
  localparam int TPS_W      = 32;
  localparam int RATE_W     = 20;
  localparam int FRAC_W     = 8;
  localparam int SHOWN_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DVD_W  = TPS_W + 8;
  localparam int DVR_W  = STAMP_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam int HISTORY_DEPTH_DEF = 10;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  localparam logic [TPS_W-1:0]  TPS_RST        = 32'd1000000;
  localparam logic [RATE_W-1:0] START_RATE_RST = 20'd7680;
  localparam logic [FRAC_W-1:0] SPIKE_FRAC_RST = 8'd13;
  localparam logic [RATE_W-1:0] JUMP_LIMIT_RST = 20'd1024;
  localparam logic [RATE_W-1:0] DIFF_CAP_RST   = 20'd1280;
  localparam logic [FRAC_W-1:0] DIFF_FRAC_RST  = 8'd13;

  localparam logic [CFG_IDX_W-1:0] CFG_TPS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_FRAC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_CAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_FRAC  = 3'd5;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              ovf;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              commit;
    logic [RATE_W-1:0] rate;
  } hist_cmd_t;

  typedef struct packed {
    logic [RATE_W-1:0] h1;
    logic [RATE_W-1:0] h2;
  } hist_st_t;

endpackage

FILE: rtl/core/frs_in_if.sv
// Input word channel: one frame timestamp.
interface frs_in_if
  import frs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink (input valid, input timestamp, output ready);
endinterface

FILE: rtl/core/frs_out_if.sv
// Result word channel: shown rate and flags.
interface frs_out_if
  import frs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SHOWN_W-1:0] shown_rate;
  logic               updated;
  logic               skipped;

  modport source (output valid, output shown_rate, output updated, output skipped,
                  input ready);
  modport sink (input valid, input shown_rate, input updated, input skipped,
                output ready);
endinterface

FILE: rtl/core/frs_cfg_if.sv
// Configuration write channel: register index and data.
interface frs_cfg_if
  import frs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/frame_rate_smoother.sv
// Frame rate smoother top level: sequencer, configuration and result register.
//
// Usage: in_ch carries one frame timestamp per word; out_ch returns one word
// per input with the shown integer rate, an updated flag and a skipped flag.
// cfg_ch writes the six registers by index (always ready; unknown indexes
// are ignored). cfg_ch is to be used only while the block is idle; the
// block itself does not enforce this. A first frame takes the start rate
// and a zero interval the maximum rate, with no division; other frames
// divide ticks*256 by the elapsed time. A kept frame then averages the
// history; a skipped one goes straight to the result. One word is in flight
// at a time; the next input word is taken the cycle after the result is
// loaded. Both divisions use the shared serial divider, one quotient bit
// per cycle: 40 steps for ticks*256/elapsed, SUM_W for the history average.
// Reset (synchronous, rst_n low) restores register defaults and clears the
// history, sum, spike state and shown rate.
// A stalled receiver holds the result word; the next input word is still
// taken and processed, and its result waits until the output register frees.
module frame_rate_smoother
  import frs_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  frs_in_if.sink    in_ch,
  frs_out_if.source out_ch,
  frs_cfg_if.sink   cfg_ch
);

  localparam int SUM_W  = RATE_W + $clog2(HISTORY_DEPTH);
  localparam int AVG_SH = DVD_W - SUM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_EVAL, S_AVG, S_AVGW, S_FIN
  } state_t;

  state_t state_r;

  logic [TPS_W-1:0]   tps_r;
  logic [RATE_W-1:0]  start_rate_r;
  logic [FRAC_W-1:0]  spike_frac_r;
  logic [RATE_W-1:0]  jump_limit_r;
  logic [RATE_W-1:0]  diff_cap_r;
  logic [FRAC_W-1:0]  diff_frac_r;

  logic [STAMP_W-1:0] last_stamp_r;
  logic               started_r;
  logic               pend_r;
  logic [SHOWN_W-1:0] cur_r;
  logic [RATE_W-1:0]  rate_r;
  logic [RATE_W-1:0]  avg_r;
  logic [RATE_W-1:0]  maxd_r;
  logic               skip_r;
  logic               tup_r;
  logic               tdn_r;

  logic               out_valid_r;
  logic [SHOWN_W-1:0] out_shown_r;
  logic               out_upd_r;
  logic               out_skip_r;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  hist_cmd_t          hist_cmd;
  hist_st_t           hist_st;
  logic [SUM_W-1:0]   hist_sum;

  logic               in_acc;
  logic [STAMP_W-1:0] elapsed;
  logic [RATE_W-1:0]  rate_gap;
  logic               spike;
  logic               skip_c;
  logic [RATE_W-1:0]  prod_md;
  logic [RATE_W-1:0]  shown_q;
  logic               gt;
  logic               lt;
  logic [RATE_W-1:0]  adiff;
  logic               fire;
  logic               fin_go;

  frs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  frs_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hist_cmd),
    .st    (hist_st),
    .sum   (hist_sum)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign elapsed      = in_ch.timestamp - last_stamp_r;

  always_comb begin
    div_req.start    = (in_acc && started_r && (elapsed != '0)) || (state_r == S_AVG);
    div_req.dividend = (state_r == S_AVG) ? (DVD_W'(hist_sum) << AVG_SH) : {tps_r, 8'd0};
    div_req.divisor  = (state_r == S_AVG) ? DVR_W'(HISTORY_DEPTH) : elapsed;
    div_req.steps    = (state_r == S_AVG) ? STEP_W'(SUM_W) : STEP_W'(DVD_W);
  end

  always_comb begin
    rate_gap = (hist_st.h1 > rate_r) ? hist_st.h1 - rate_r : rate_r - hist_st.h1;
    spike    = ({rate_gap, 8'd0} > ((RATE_W + 8)'(spike_frac_r) * (RATE_W + 8)'(hist_st.h1)));
    skip_c   = spike && !pend_r;
    prod_md  = RATE_W'(diff_frac_r) * RATE_W'(cur_r);
    hist_cmd.commit = (state_r == S_EVAL) && !skip_c;
    hist_cmd.rate   = rate_r;
  end

  always_comb begin
    shown_q = {cur_r, 8'd0};
    gt      = avg_r > shown_q;
    lt      = avg_r < shown_q;
    adiff   = gt ? avg_r - shown_q : shown_q - avg_r;
    fire    = !skip_r && ((tup_r && (gt || (lt && adiff > jump_limit_r))) ||
                          (tdn_r && (lt || (gt && adiff > jump_limit_r))) ||
                          (adiff > maxd_r));
    fin_go  = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r        <= TPS_RST;
      start_rate_r <= START_RATE_RST;
      spike_frac_r <= SPIKE_FRAC_RST;
      jump_limit_r <= JUMP_LIMIT_RST;
      diff_cap_r   <= DIFF_CAP_RST;
      diff_frac_r  <= DIFF_FRAC_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TPS:        tps_r        <= cfg_ch.data;
        CFG_START_RATE: start_rate_r <= cfg_ch.data[RATE_W-1:0];
        CFG_SPIKE_FRAC: spike_frac_r <= cfg_ch.data[FRAC_W-1:0];
        CFG_JUMP_LIMIT: jump_limit_r <= cfg_ch.data[RATE_W-1:0];
        CFG_DIFF_CAP:   diff_cap_r   <= cfg_ch.data[RATE_W-1:0];
        CFG_DIFF_FRAC:  diff_frac_r  <= cfg_ch.data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_stamp_r <= '0;
      started_r    <= 1'b0;
      pend_r       <= 1'b0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= fin_go || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            last_stamp_r <= in_ch.timestamp;
            started_r    <= 1'b1;
            if (!started_r) begin
              rate_r  <= start_rate_r;
              state_r <= S_EVAL;
            end else if (elapsed == '0) begin
              rate_r  <= RATE_MAX;
              state_r <= S_EVAL;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            rate_r  <= div_rsp.ovf ? RATE_MAX : div_rsp.quotient;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          pend_r <= spike;
          skip_r <= skip_c;
          tdn_r  <= (hist_st.h2 > hist_st.h1) && (hist_st.h1 > rate_r);
          tup_r  <= (hist_st.h2 < hist_st.h1) && (hist_st.h1 < rate_r);
          maxd_r <= (prod_md > diff_cap_r) ? diff_cap_r : prod_md;
          state_r <= skip_c ? S_FIN : S_AVG;
        end
        S_AVG: begin
          state_r <= S_AVGW;
        end
        S_AVGW: begin
          if (div_rsp.done) begin
            avg_r   <= div_rsp.quotient;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_upd_r   <= fire;
            out_skip_r  <= skip_r;
            out_shown_r <= fire ? avg_r[RATE_W-1:8] : cur_r;
            if (fire) begin
              cur_r <= avg_r[RATE_W-1:8];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.shown_rate = out_shown_r;
  assign out_ch.updated    = out_upd_r;
  assign out_ch.skipped    = out_skip_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken while an item is in work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.updated && out_ch.skipped))
    else $error("skipped word reports an update");

  a_skip_holds_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.skipped |-> out_ch.shown_rate == cur_r)
    else $error("skipped word changed the shown rate");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

endmodule

FILE: rtl/core/frs_div.sv
// Shared restoring divider, one quotient bit per cycle, saturating overflow flag.
module frs_div
  import frs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVR_W-1:0]  dvr_r;
  logic [DVR_W-1:0]  rem_r;
  logic [RATE_W-1:0] q_r;
  logic              ovf_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVR_W:0]    trial;
  logic              qbit;
  logic [DVR_W:0]    diff;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dvr_r};
    qbit  = (trial >= {1'b0, dvr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvr_r <= req.divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= qbit ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
      q_r   <= {q_r[RATE_W-2:0], qbit};
      ovf_r <= ovf_r | q_r[RATE_W-1];
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.ovf      = ovf_r;
  assign rsp.quotient = q_r;

endmodule

FILE: rtl/core/frs_hist.sv
// Rate history ring with running sum and the two newest entries.
module frs_hist
  import frs_pkg::*;
#(
  parameter int DEPTH = HISTORY_DEPTH_DEF,
  localparam int SUM_W = RATE_W + $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hist_cmd_t        cmd,
  output hist_st_t         st,
  output logic [SUM_W-1:0] sum
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [RATE_W-1:0] mem_r [DEPTH];
  logic [RATE_W-1:0] rd_r;
  logic [IDX_W-1:0]  head_r;
  logic              full_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RATE_W-1:0] h1_r;
  logic [RATE_W-1:0] h2_r;
  logic [RATE_W-1:0] oldest;

  assign oldest = full_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    rd_r <= mem_r[head_r];
    if (cmd.commit) begin
      mem_r[head_r] <= cmd.rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
      h1_r   <= '0;
      h2_r   <= '0;
    end else if (cmd.commit) begin
      sum_r <= sum_r - SUM_W'(oldest) + SUM_W'(cmd.rate);
      h2_r  <= h1_r;
      h1_r  <= cmd.rate;
      if (head_r == IDX_W'(DEPTH - 1)) begin
        head_r <= '0;
        full_r <= 1'b1;
      end else begin
        head_r <= head_r + 1'b1;
      end
    end
  end

  assign st.h1 = h1_r;
  assign st.h2 = h2_r;
  assign sum   = sum_r;

endmodule
